>>> rtl/octahedral_normal_codec_assert.svh
// Assertion macros for the octahedral normal codec checker.
// Each macro expects clk and rst_n in scope.
`ifndef OCTAHEDRAL_NORMAL_CODEC_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_CODEC_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define OCN_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ocn check failed: invariant");

// Implication checked at the same clock edge.
`define OCN_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ocn check failed: implication");

`endif

>>> rtl/ocn_pkg.sv
package ocn_pkg;

    // Command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Datapath sizes
    localparam int LANES      = 3;
    localparam int DIV_W      = 32;   // divisor width
    localparam int REM_W      = 33;   // partial remainder width
    localparam int QUO_W      = 33;   // quotient bits, one per divider cell
    localparam int ROOT_W     = 17;   // root bits, one per root cell
    localparam int DIV_CELLS  = QUO_W;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int LATENCY    = 2 + DIV_CELLS + SQRT_CELLS + 1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
        logic        [15:0] in_u;
        logic        [15:0] in_v;
    } request_t;

    typedef struct packed {
        logic        [15:0] code_u;
        logic        [15:0] code_v;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               zero_vector;
    } result_t;

    // Data handed along the divider row
    typedef struct packed {
        logic                            command;
        logic                            zero;
        logic [LANES-1:0]                neg;
        logic [DIV_W-1:0]                divisor;
        logic [LANES-1:0][REM_W-1:0]     rem;
        logic [LANES-1:0][QUO_W-1:0]     quot;
    } div_data_t;

    // Data handed along the square root row
    typedef struct packed {
        logic                            command;
        logic                            zero;
        logic [LANES-1:0]                neg;
        logic [LANES-1:0][QUO_W-1:0]     rad;
        logic [LANES-1:0][ROOT_W-1:0]    root;
    } sqrt_data_t;

endpackage

>>> rtl/ocn_div_cell.sv
module ocn_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  ocn_pkg::div_data_t data_in,
    output logic              valid_out,
    output ocn_pkg::div_data_t data_out
);

    logic               valid_reg;
    ocn_pkg::div_data_t data_reg;
    ocn_pkg::div_data_t data_next;

    // Retire one quotient bit on every lane
    always_comb
    begin
        logic [ocn_pkg::REM_W-1:0] trial;
        logic [ocn_pkg::REM_W-1:0] dvs;
        logic                      ge;
        data_next = data_in;
        dvs = {1'b0, data_in.divisor};
        for (int i = 0; i < ocn_pkg::LANES; i++)
        begin
            if (FIRST)
            begin
                trial = data_in.rem[i];
            end
            else
            begin
                trial = {data_in.rem[i][ocn_pkg::REM_W-2:0], 1'b0};
            end
            ge = (trial >= dvs);
            data_next.rem[i]  = ge ? (trial - dvs) : trial;
            data_next.quot[i] = {data_in.quot[i][ocn_pkg::QUO_W-2:0], ge};
        end
    end

    // Advance the valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> rtl/ocn_sqrt_cell.sv
module ocn_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  ocn_pkg::sqrt_data_t data_in,
    output logic               valid_out,
    output ocn_pkg::sqrt_data_t data_out
);

    logic                valid_reg;
    ocn_pkg::sqrt_data_t data_reg;
    ocn_pkg::sqrt_data_t data_next;

    // Try one root bit on every lane, keep it when the square still fits
    always_comb
    begin
        logic [ocn_pkg::ROOT_W-1:0]   trial;
        logic [2*ocn_pkg::ROOT_W-1:0] sq;
        data_next = data_in;
        for (int i = 0; i < ocn_pkg::LANES; i++)
        begin
            trial = data_in.root[i] | (ocn_pkg::ROOT_W'(1) << BIT);
            sq    = trial * trial;
            if (sq <= (2*ocn_pkg::ROOT_W)'(data_in.rad[i]))
            begin
                data_next.root[i] = trial;
            end
        end
    end

    // Advance the valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> rtl/octahedral_normal_codec.sv
// Octahedral normal codec. Each request carries a command: encode turns a
// Q1.15 normal into a Q0.16 octahedral code, decode turns a code back into a
// Q1.15 unit normal. The block is fully pipelined: a request is taken in every
// clock cycle (busy stays low). Its result is on result, marked by done for
// one cycle. The pipeline has 53 register stages: two front stages, a row
// of 33 restoring divider cells (one quotient bit each), a row of 17 square
// root cells (one root bit each) and one output stage. The receiver cannot
// stall, so results must be taken in the cycle done is high. A zero input
// vector on encode yields code (0.5, 0.5) with zero_vector set.
module octahedral_normal_codec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ocn_pkg::request_t request,
    output logic              done,
    output ocn_pkg::result_t  result
);

    localparam int NDIV  = ocn_pkg::DIV_CELLS;
    localparam int NSQRT = ocn_pkg::SQRT_CELLS;

    // Front stage 0 registers
    logic                     s0_valid_reg;
    logic                     s0_cmd_reg;
    logic                     s0_zero_reg;
    logic [17:0]              s0_num_reg [2];
    logic [17:0]              s0_sum2_reg;
    logic signed [17:0]       s0_m_reg [3];

    logic                     s0_zero_next;
    logic [17:0]              s0_num_next [2];
    logic [17:0]              s0_sum2_next;
    logic signed [17:0]       s0_m_next [3];

    // Front stage 1 registers feed the divider row
    logic                     s1_valid_reg;
    ocn_pkg::div_data_t       s1_data_reg;
    ocn_pkg::div_data_t       s1_data_next;

    logic                     div_valid [NDIV+1];
    ocn_pkg::div_data_t       div_data  [NDIV+1];
    logic                     sq_valid  [NSQRT+1];
    ocn_pkg::sqrt_data_t      sq_data   [NSQRT+1];

    logic                     done_reg;
    ocn_pkg::result_t         result_reg;
    ocn_pkg::result_t         result_next;

    logic                     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fold and project the request for encode, center and unfold the code for decode
    always_comb
    begin
        logic [16:0]        ax, ay, az;
        logic [16:0]        sum;
        logic signed [16:0] hx, hy;
        logic [16:0]        ahx, ahy;
        logic signed [17:0] hz, fold;
        ax = request.in_x[15] ? 17'(-{request.in_x[15], request.in_x})
                              : {1'b0, request.in_x};
        ay = request.in_y[15] ? 17'(-{request.in_y[15], request.in_y})
                              : {1'b0, request.in_y};
        az = request.in_z[15] ? 17'(-{request.in_z[15], request.in_z})
                              : {1'b0, request.in_z};
        sum = 17'(ax + ay + az);
        s0_zero_next = (sum == 17'd0) && (request.command == ocn_pkg::CMD_ENCODE);
        s0_sum2_next = {sum, 1'b0};
        if (request.in_z[15])
        begin
            s0_num_next[0] = request.in_x[15] ? {1'b0, ay} : 18'(s0_sum2_next - {1'b0, ay});
            s0_num_next[1] = request.in_y[15] ? {1'b0, ax} : 18'(s0_sum2_next - {1'b0, ax});
        end
        else
        begin
            s0_num_next[0] = 18'({1'b0, sum} + {{2{request.in_x[15]}}, request.in_x});
            s0_num_next[1] = 18'({1'b0, sum} + {{2{request.in_y[15]}}, request.in_y});
        end

        // Decode: center the code and unfold the outer triangles
        hx   = 17'({1'b0, request.in_u} - 17'd32768);
        hy   = 17'({1'b0, request.in_v} - 17'd32768);
        ahx  = hx[16] ? 17'(-hx) : 17'(hx);
        ahy  = hy[16] ? 17'(-hy) : 17'(hy);
        hz   = 18'(18'sd32768 - $signed({1'b0, ahx}) - $signed({1'b0, ahy}));
        fold = hz[17] ? 18'(-hz) : 18'sd0;
        s0_m_next[0] = hx[16] ? 18'({hx[16], hx} + fold) : 18'({hx[16], hx} - fold);
        s0_m_next[1] = hy[16] ? 18'({hy[16], hy} + fold) : 18'({hy[16], hy} - fold);
        s0_m_next[2] = hz;
    end

    // Square the decode vector and load the divider row
    always_comb
    begin
        logic [16:0] am [3];
        logic [30:0] sq [3];
        logic [31:0] ssum;
        for (int i = 0; i < 3; i++)
        begin
            am[i] = s0_m_reg[i][17] ? 17'(-s0_m_reg[i]) : 17'(s0_m_reg[i]);
            sq[i] = 31'({14'd0, am[i]} * {14'd0, am[i]});
        end
        ssum = 32'({1'b0, sq[0]}) + 32'({1'b0, sq[1]}) + 32'({1'b0, sq[2]});
        s1_data_next         = '0;
        s1_data_next.command = s0_cmd_reg;
        s1_data_next.zero    = s0_zero_reg;
        if (s0_cmd_reg == ocn_pkg::CMD_DECODE)
        begin
            s1_data_next.divisor = ssum;
            for (int i = 0; i < 3; i++)
            begin
                s1_data_next.rem[i] = ocn_pkg::REM_W'(sq[i]);
                s1_data_next.neg[i] = s0_m_reg[i][17];
            end
        end
        else
        begin
            s1_data_next.divisor = ocn_pkg::DIV_W'(s0_sum2_reg);
            s1_data_next.rem[0]  = ocn_pkg::REM_W'(s0_num_reg[0]);
            s1_data_next.rem[1]  = ocn_pkg::REM_W'(s0_num_reg[1]);
        end
    end

    // Hold the front stage valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    // Advance the front stage payload
    always_ff @(posedge clk)
    begin
        s0_cmd_reg  <= request.command;
        s0_zero_reg <= s0_zero_next;
        s0_sum2_reg <= s0_sum2_next;
        for (int i = 0; i < 2; i++)
        begin
            s0_num_reg[i] <= s0_num_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            s0_m_reg[i] <= s0_m_next[i];
        end
        s1_data_reg <= s1_data_next;
    end

    // Divider row: quotient of numerator over divisor, one bit per cell
    assign div_valid[0] = s1_valid_reg;
    assign div_data[0]  = s1_data_reg;

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        ocn_div_cell #(
            .FIRST (g == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (div_valid[g]),
            .data_in   (div_data[g]),
            .valid_out (div_valid[g+1]),
            .data_out  (div_data[g+1])
        );
    end

    // Square root row takes the quotients as radicands
    always_comb
    begin
        sq_valid[0]         = div_valid[NDIV];
        sq_data[0]          = '0;
        sq_data[0].command  = div_data[NDIV].command;
        sq_data[0].zero     = div_data[NDIV].zero;
        sq_data[0].neg      = div_data[NDIV].neg;
        sq_data[0].rad      = div_data[NDIV].quot;
    end

    for (genvar g = 0; g < NSQRT; g++)
    begin : g_sqrt
        ocn_sqrt_cell #(
            .BIT (NSQRT - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[g]),
            .data_in   (sq_data[g]),
            .valid_out (sq_valid[g+1]),
            .data_out  (sq_data[g+1])
        );
    end

    // Round and saturate the final values
    always_comb
    begin
        logic [17:0] code [2];
        logic [17:0] half;
        logic [16:0] mag;
        logic [15:0] comp [3];
        result_next = '0;
        code[0]     = '0;
        code[1]     = '0;
        half        = '0;
        mag         = '0;
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = '0;
        end
        if (sq_data[NSQRT].command == ocn_pkg::CMD_ENCODE)
        begin
            for (int i = 0; i < 2; i++)
            begin
                code[i] = 18'(sq_data[NSQRT].rad[i][32:16])
                        + 18'(sq_data[NSQRT].rad[i][15]);
            end
            if (sq_data[NSQRT].zero)
            begin
                result_next.code_u      = 16'd32768;
                result_next.code_v      = 16'd32768;
                result_next.zero_vector = 1'b1;
            end
            else
            begin
                result_next.code_u = (code[0] > 18'd65535) ? 16'hFFFF : code[0][15:0];
                result_next.code_v = (code[1] > 18'd65535) ? 16'hFFFF : code[1][15:0];
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                half = 18'(sq_data[NSQRT].root[i]) + 18'd1;
                mag  = half[17:1];
                if (sq_data[NSQRT].neg[i])
                begin
                    comp[i] = 16'(-mag);
                end
                else
                begin
                    comp[i] = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
                end
            end
            result_next.unit_x = comp[0];
            result_next.unit_y = comp[1];
            result_next.unit_z = comp[2];
        end
    end

    // Hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_valid[NSQRT];
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/ocn_checker.sv
`include "octahedral_normal_codec_assert.svh"

module ocn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ocn_pkg::request_t request,
    input logic              done,
    input ocn_pkg::result_t  result
);

    localparam int LAT = ocn_pkg::LATENCY;

    // Count cycles since reset so the latency check skips the fill window
    logic [6:0] age_reg;
    logic       filled;
    logic       unit_clear;
    logic       code_half;
    logic       code_set;

    assign filled     = (age_reg >= 7'(LAT));
    assign unit_clear = (result.unit_x == 16'sd0) && (result.unit_y == 16'sd0)
                     && (result.unit_z == 16'sd0);
    assign code_half  = (result.code_u == 16'd32768) && (result.code_v == 16'd32768);
    assign code_set   = (result.code_u != 16'd0) || (result.code_v != 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (age_reg < 7'(LAT))
        begin
            age_reg <= age_reg + 7'd1;
        end
    end

    `OCN_ALWAYS(a_never_busy, !busy)
    `OCN_IMPLIES(a_fixed_latency, filled, done == $past(start && !busy, LAT))
    `OCN_IMPLIES(a_zero_code, done && result.zero_vector, code_half && unit_clear)
    `OCN_IMPLIES(a_one_mode, done && code_set, unit_clear)

endmodule

bind octahedral_normal_codec ocn_checker u_ocn_checker (.*);
